// ----- rtl/drop_fall_split_trace_macros.svh -----
// Assertion macros shared by the drop-fall split trace RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef DROP_FALL_SPLIT_TRACE_MACROS_SVH
`define DROP_FALL_SPLIT_TRACE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DFST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition in the next cycle follows from a trigger.
`define DFST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dfst_pkg.sv -----
// Package for the drop-fall split trace block: sizes, payload and command types.
// Used by every RTL file of the block; depends on nothing.
package dfst_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int DIM_W       = 7;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int POS_W       = $clog2(STORE_DEPTH + 1);
  localparam int PIX_W       = 8;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reciprocal multiply for w/3, exact for every width up to 64.
  localparam int DIV3_MUL   = 43;
  localparam int DIV3_SHIFT = 7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] cut_column;
    logic             split_status;
    logic [COL_W-1:0] min_column;
    logic [COL_W-1:0] max_column;
    logic             last_result;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_TRACE,
    CMD_WRITE_TRACE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Map a raw dimension register onto 1..maxv.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  // w/3 by reciprocal multiply.
  function automatic logic [COL_W-1:0] div3(input logic [DIM_W-1:0] w);
    logic [2*DIM_W-1:0] p;
    p = {{DIM_W{1'b0}}, w} * (2*DIM_W)'(DIV3_MUL);
    return p[DIV3_SHIFT +: COL_W];
  endfunction

endpackage

// ----- rtl/drop_fall_split_trace.sv -----
// Drop-fall split trace. Load a grey image (raster order, one pixel per transaction,
// last_pixel on the final one); then the block picks a start column in [w/3, 3w/4)
// with the longest white run from the top (w/2 if none), traces a drop-fall path
// from row 0 and returns one result transaction per row with the last trace column,
// the split status and the min/max trace columns. Pixels load at one per cycle, while
// the input is not stalled, into a command queue; the back end owns a 4096 x 8 image
// memory with a single read port, which the scan uses for each scanned column until
// its first non-white pixel and each trace step for its five neighbor reads. While a
// trace runs, pixels of the next image wait in the 4-entry queue and then stall. A
// width write stalls input while the load position is re-divided. Configure only while
// the block is idle; pixels past width*height are dropped.
// Depends on dfst_pkg, dfst_front, dfst_queue and dfst_back.
module drop_fall_split_trace import dfst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pixel_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output result_t              out_data_o
);

  logic [DIM_W-1:0] width_q, height_q;
  dims_t            dims;
  logic             push, pop;
  cmd_t             push_cmd, pop_cmd;
  queue_status_t    q_status;

  // Hold the raw registers; clamp them to 1..max for the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  always_comb begin
    dims.width  = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
    dims.height = clamp_dim(height_q, DIM_W'(MAX_HEIGHT));
  end

  // Front: accept pixels, assign addresses, queue write and trace commands.
  dfst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dims_i     (dims),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (q_status.full)
  );

  // Decouple loading from tracing.
  dfst_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .status_o   (q_status)
  );

  // Back: write the image, scan, trace and emit per-row results.
  dfst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .cmd_avail_i (!q_status.empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/dfst_front.sv -----
// Front end of the drop-fall split trace: accepts pixels, places them in the image
// and queues write and trace commands. Depends on dfst_pkg.
`include "drop_fall_split_trace_macros.svh"

module dfst_front import dfst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dims_t     dims_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pixel_in_t in_data_i,
  output logic      push_o,
  output cmd_t      push_cmd_o,
  input  logic      full_i
);

  localparam int DIV_CNT_W = $clog2(POS_W + 1);
  localparam logic [DIM_W-1:0] ROW_SAT = DIM_W'(MAX_HEIGHT);

  logic [POS_W-1:0]     pos_q, pos_d;
  logic [DIM_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [DIM_W-1:0]     wprev_q, wprev_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [DIM_W-1:0]     div_rem_q, div_rem_d;
  logic [POS_W-1:0]     div_quo_q, div_quo_d;
  logic [POS_W-1:0]     div_dvd_q, div_dvd_d;

  logic [DIM_W-1:0] w, h;
  logic             w_changed, div_busy, accept, in_image;
  logic [DIM_W:0]   trial;
  logic             take;
  logic [DIM_W-1:0] rem_n;
  logic [POS_W-1:0] quo_n;

  always_comb begin
    w         = dims_i.width;
    h         = dims_i.height;
    w_changed = (w != wprev_q);
    div_busy  = (div_cnt_q != '0);
    in_stall_o = full_i | div_busy | w_changed;
    accept    = in_valid_i & ~in_stall_o;
    in_image  = (row_q < h);

    // One restoring-division step of the load position by the width.
    trial = {div_rem_q, div_dvd_q[POS_W-1]};
    take  = (trial >= {1'b0, w});
    rem_n = take ? DIM_W'(trial - {1'b0, w}) : trial[DIM_W-1:0];
    quo_n = {div_quo_q[POS_W-2:0], take};
  end

  always_comb begin
    push_cmd_o.addr = {row_q[ROW_W-1:0], col_q};
    push_cmd_o.data = in_data_i.pixel;
    if (in_image && in_data_i.last_pixel) begin
      push_cmd_o.kind = CMD_WRITE_TRACE;
    end else if (in_image) begin
      push_cmd_o.kind = CMD_WRITE;
    end else begin
      push_cmd_o.kind = CMD_TRACE;
    end
    // Drop pixels beyond the image unless they close it.
    push_o = accept & (in_image | in_data_i.last_pixel);
  end

  always_comb begin
    pos_d     = pos_q;
    row_d     = row_q;
    col_d     = col_q;
    wprev_d   = wprev_q;
    div_cnt_d = div_cnt_q;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_dvd_d = div_dvd_q;
    if (w_changed) begin
      // Re-derive row and column of the load position under the new width.
      wprev_d   = w;
      div_cnt_d = DIV_CNT_W'(POS_W);
      div_rem_d = '0;
      div_quo_d = '0;
      div_dvd_d = pos_q;
    end else if (div_busy) begin
      div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
      div_rem_d = rem_n;
      div_quo_d = quo_n;
      div_dvd_d = {div_dvd_q[POS_W-2:0], 1'b0};
      if (div_cnt_q == DIV_CNT_W'(1)) begin
        row_d = (quo_n > POS_W'(MAX_HEIGHT)) ? ROW_SAT : quo_n[DIM_W-1:0];
        col_d = rem_n[COL_W-1:0];
      end
    end else if (accept) begin
      if (in_data_i.last_pixel) begin
        pos_d = '0;
        row_d = '0;
        col_d = '0;
      end else if (pos_q != POS_W'(STORE_DEPTH)) begin
        pos_d = pos_q + POS_W'(1);
        if (({1'b0, col_q} + DIM_W'(1)) == w) begin
          col_d = '0;
          if (row_q != ROW_SAT) begin
            row_d = row_q + DIM_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      wprev_q   <= DIM_W'(MAX_WIDTH);
      div_cnt_q <= '0;
      div_rem_q <= '0;
      div_quo_q <= '0;
      div_dvd_q <= '0;
    end else begin
      pos_q     <= pos_d;
      row_q     <= row_d;
      col_q     <= col_d;
      wprev_q   <= wprev_d;
      div_cnt_q <= div_cnt_d;
      div_rem_q <= div_rem_d;
      div_quo_q <= div_quo_d;
      div_dvd_q <= div_dvd_d;
    end
  end

  `DFST_ASSERT(a_col_in_row, (!div_busy && !w_changed) |-> ({1'b0, col_q} < w), "load column left the row")

endmodule

// ----- rtl/dfst_queue.sv -----
// Short command queue between the front and back of the drop-fall split trace.
// Depends on dfst_pkg.
module dfst_queue import dfst_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_cmd_i,
  input  logic          pop_i,
  output cmd_t          pop_cmd_o,
  output queue_status_t status_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
    status_o.empty = (count_q == '0);
    pop_cmd_o      = entry_q[rd_ptr_q];
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/dfst_back.sv -----
// Back end of the drop-fall split trace: owns the image and row-cut memories,
// runs the start-column scan and the trace, and drives the result register.
// Depends on dfst_pkg.
`include "drop_fall_split_trace_macros.svh"

module dfst_back import dfst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dims_t   dims_i,
  input  logic    cmd_avail_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_COL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TR_INIT,
    ST_TR_CHECK,
    ST_TR_RD,
    ST_TR_STEP,
    ST_EMIT_RD,
    ST_EMIT_PUT
  } state_e;

  // Neighbor fetch order during a trace step.
  localparam int NB_NUM = 5;
  localparam int SUB_W  = 3;
  localparam logic [SUB_W-1:0] NB_L  = 3'd0;
  localparam logic [SUB_W-1:0] NB_R  = 3'd1;
  localparam logic [SUB_W-1:0] NB_D  = 3'd2;
  localparam logic [SUB_W-1:0] NB_DL = 3'd3;
  localparam logic [SUB_W-1:0] NB_DR = 3'd4;
  localparam logic [SUB_W-1:0] NB_LAST_SUB = 3'd5;

  state_e           state_q;
  logic [COL_W-1:0] scan_col_q;
  logic [DIM_W-1:0] scan_row_q;
  logic [DIM_W-1:0] best_dep_q;
  logic [COL_W-1:0] best_col_q;
  logic [COL_W-1:0] tr_col_q;
  logic [ROW_W-1:0] tr_row_q;
  logic             tr_flag_q;
  logic [COL_W-1:0] mn_q, mx_q;
  logic [SUB_W-1:0] sub_q;
  logic [NB_NUM-1:0] nb_blk_q, nb_wht_q;
  logic [ROW_W-1:0] emit_k_q;
  logic             out_valid_q;
  result_t          out_q;

  logic [PIX_W-1:0] img_mem [STORE_DEPTH];
  logic [PIX_W-1:0] img_rd_q;
  logic [COL_W-1:0] rc_mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] rc_valid_q;
  logic [COL_W-1:0] rc_rd_q;
  logic             rc_vld_rd_q;

  logic [DIM_W-1:0]  w, h;
  logic [COL_W-1:0]  scan_lo, scan_hi, scan_mid;
  logic [DIM_W:0]    w_x3;
  logic              img_we, trace_start;
  logic [ADDR_W-1:0] img_raddr;
  logic              tr_run;
  logic              rc_we;
  logic [ROW_W-1:0]  rc_waddr;
  logic [COL_W-1:0]  rc_wdata;
  logic [ROW_W-1:0]  row_up;
  logic [COL_W-1:0]  col_lf, col_rt;
  logic              b_l, b_r, b_d, b_dl, b_dr, w_l, w_r, w_d, w_dl, w_dr;
  logic [COL_W-1:0]  nxt_col;
  logic [ROW_W-1:0]  nxt_row;
  logic              nxt_flag;
  logic              emit_last;

  // Scan window and default start column.
  always_comb begin
    w        = dims_i.width;
    h        = dims_i.height;
    w_x3     = {w, 1'b0} + {1'b0, w};
    scan_lo  = div3(w);
    scan_hi  = w_x3[DIM_W:2];
    scan_mid = w[DIM_W-1:1];
  end

  // Command decode at the head of the queue.
  always_comb begin
    pop_o       = (state_q == ST_IDLE) && cmd_avail_i;
    img_we      = 1'b0;
    trace_start = 1'b0;
    unique case (cmd_i.kind)
      CMD_WRITE: begin
        img_we = pop_o;
      end
      CMD_TRACE: begin
        trace_start = pop_o;
      end
      CMD_WRITE_TRACE: begin
        img_we      = pop_o;
        trace_start = pop_o;
      end
      default: begin
        img_we      = 1'b0;
        trace_start = 1'b0;
      end
    endcase
  end

  // Image read address: scan pixel or trace neighbor.
  always_comb begin
    row_up = tr_row_q + ROW_W'(1);
    col_lf = tr_col_q - COL_W'(1);
    col_rt = tr_col_q + COL_W'(1);
    img_raddr = '0;
    if (state_q == ST_SCAN_RD) begin
      img_raddr = {scan_row_q[ROW_W-1:0], scan_col_q};
    end else if (state_q == ST_TR_RD) begin
      case (sub_q)
        NB_L:    img_raddr = {tr_row_q, col_lf};
        NB_R:    img_raddr = {tr_row_q, col_rt};
        NB_D:    img_raddr = {row_up, tr_col_q};
        NB_DL:   img_raddr = {row_up, col_lf};
        NB_DR:   img_raddr = {row_up, col_rt};
        default: img_raddr = '0;
      endcase
    end
  end

  // Keep every neighbor inside the image while the trace runs.
  always_comb begin
    tr_run = (tr_col_q != '0)
          && (({1'b0, tr_col_q} + DIM_W'(1)) < w)
          && (({1'b0, tr_row_q} + DIM_W'(1)) < h);
  end

  // Drop-fall neighbor rules.
  always_comb begin
    b_l  = nb_blk_q[NB_L];
    b_r  = nb_blk_q[NB_R];
    b_d  = nb_blk_q[NB_D];
    b_dl = nb_blk_q[NB_DL];
    b_dr = nb_blk_q[NB_DR];
    w_l  = nb_wht_q[NB_L];
    w_r  = nb_wht_q[NB_R];
    w_d  = nb_wht_q[NB_D];
    w_dl = nb_wht_q[NB_DL];
    w_dr = nb_wht_q[NB_DR];
    nxt_row  = row_up;
    nxt_col  = tr_col_q;
    nxt_flag = tr_flag_q;
    if ((&nb_blk_q) || (&nb_wht_q) || (b_dl && w_d)) begin
      nxt_flag = 1'b0;
    end else if (b_l && b_r && b_d && w_dl && b_dr) begin
      nxt_col  = col_lf;
      nxt_flag = 1'b0;
    end else if (b_d && b_dl && w_dr) begin
      nxt_col  = col_rt;
      nxt_flag = 1'b0;
    end else if (w_r && b_d && b_dl && b_dr) begin
      if (!tr_flag_q) begin
        nxt_row  = tr_row_q;
        nxt_col  = col_rt;
        nxt_flag = 1'b1;
      end else begin
        nxt_flag = 1'b0;
      end
    end else if (w_l && b_d && b_dl && b_dr) begin
      if (!tr_flag_q) begin
        nxt_row  = tr_row_q;
        nxt_col  = col_lf;
        nxt_flag = 1'b1;
      end else begin
        nxt_flag = 1'b0;
      end
    end
  end

  // Row-cut writes: start column at row 0, then each trace position.
  always_comb begin
    rc_we    = (state_q == ST_TR_INIT) || (state_q == ST_TR_STEP);
    rc_waddr = (state_q == ST_TR_INIT) ? '0 : nxt_row;
    rc_wdata = (state_q == ST_TR_INIT) ? best_col_q : nxt_col;
    emit_last = ({1'b0, emit_k_q} == (h - DIM_W'(1)));
  end

  always_ff @(posedge clk_i) begin
    if (img_we) begin
      img_mem[cmd_i.addr] <= cmd_i.data;
    end
    img_rd_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rc_we) begin
      rc_mem[rc_waddr] <= rc_wdata;
    end
    rc_rd_q     <= rc_mem[emit_k_q];
    rc_vld_rd_q <= rc_valid_q[emit_k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_valid_q <= '0;
    end else if (trace_start) begin
      rc_valid_q <= '0;
    end else if (rc_we) begin
      rc_valid_q[rc_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_col_q  <= '0;
      scan_row_q  <= '0;
      best_dep_q  <= '0;
      best_col_q  <= '0;
      tr_col_q    <= '0;
      tr_row_q    <= '0;
      tr_flag_q   <= 1'b0;
      mn_q        <= '0;
      mx_q        <= '0;
      sub_q       <= '0;
      nb_blk_q    <= '0;
      nb_wht_q    <= '0;
      emit_k_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (trace_start) begin
            scan_col_q <= scan_lo;
            best_dep_q <= '0;
            best_col_q <= scan_mid;
            state_q    <= ST_SCAN_COL;
          end
        end
        ST_SCAN_COL: begin
          if (scan_col_q < scan_hi) begin
            scan_row_q <= '0;
            state_q    <= ST_SCAN_RD;
          end else begin
            state_q <= ST_TR_INIT;
          end
        end
        ST_SCAN_RD: begin
          if (scan_row_q < h) begin
            state_q <= ST_SCAN_CHK;
          end else begin
            if (best_dep_q < scan_row_q) begin
              best_dep_q <= scan_row_q;
              best_col_q <= scan_col_q;
            end
            scan_col_q <= scan_col_q + COL_W'(1);
            state_q    <= ST_SCAN_COL;
          end
        end
        ST_SCAN_CHK: begin
          if (img_rd_q == PIX_WHITE) begin
            scan_row_q <= scan_row_q + DIM_W'(1);
            state_q    <= ST_SCAN_RD;
          end else begin
            if (best_dep_q < scan_row_q) begin
              best_dep_q <= scan_row_q;
              best_col_q <= scan_col_q;
            end
            scan_col_q <= scan_col_q + COL_W'(1);
            state_q    <= ST_SCAN_COL;
          end
        end
        ST_TR_INIT: begin
          tr_col_q  <= best_col_q;
          tr_row_q  <= '0;
          tr_flag_q <= 1'b0;
          mn_q      <= best_col_q;
          mx_q      <= best_col_q;
          state_q   <= ST_TR_CHECK;
        end
        ST_TR_CHECK: begin
          if (tr_run) begin
            sub_q   <= '0;
            state_q <= ST_TR_RD;
          end else begin
            emit_k_q <= '0;
            state_q  <= ST_EMIT_RD;
          end
        end
        ST_TR_RD: begin
          // Capture the neighbor whose read was issued last cycle.
          if (sub_q != '0) begin
            nb_blk_q[sub_q - SUB_W'(1)] <= (img_rd_q == PIX_BLACK);
            nb_wht_q[sub_q - SUB_W'(1)] <= (img_rd_q == PIX_WHITE);
          end
          if (sub_q == NB_LAST_SUB) begin
            state_q <= ST_TR_STEP;
          end else begin
            sub_q <= sub_q + SUB_W'(1);
          end
        end
        ST_TR_STEP: begin
          tr_col_q  <= nxt_col;
          tr_row_q  <= nxt_row;
          tr_flag_q <= nxt_flag;
          if (nxt_col < mn_q) begin
            mn_q <= nxt_col;
          end
          if (nxt_col > mx_q) begin
            mx_q <= nxt_col;
          end
          state_q <= ST_TR_CHECK;
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_PUT;
        end
        ST_EMIT_PUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q        <= 1'b1;
            out_q.row_index    <= emit_k_q;
            out_q.cut_column   <= rc_vld_rd_q ? rc_rd_q : '0;
            out_q.split_status <= (mn_q == '0);
            out_q.min_column   <= mn_q;
            out_q.max_column   <= mx_q;
            out_q.last_result  <= emit_last;
            if (emit_last) begin
              state_q <= ST_IDLE;
            end else begin
              emit_k_q <= emit_k_q + ROW_W'(1);
              state_q  <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DFST_ASSERT_NEXT(a_row_moves_down, state_q == ST_TR_STEP, (tr_row_q == $past(tr_row_q)) || (tr_row_q == ($past(tr_row_q) + 6'd1)), "trace row jumped")
  `DFST_ASSERT(a_step_off_edge, (state_q == ST_TR_STEP) |-> (tr_col_q != '0), "trace step taken at column 0")
  `DFST_ASSERT(a_min_le_max, out_valid_o |-> (out_data_o.min_column <= out_data_o.max_column), "min column above max column")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for drop_fall_split_trace: streams grey images, predicts the
// per-row drop-fall cut results and checks every result transaction in order.
// Depends on dfst_pkg and the drop_fall_split_trace RTL.
module testbench;
  import dfst_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int IDLE_PCT      = 17;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_PIXELS = 380;

  // Picture content used when building an image.
  typedef enum int {
    ART_NOISE,
    ART_GLYPHS,
    ART_WHITE,
    ART_BLACK,
    ART_STRIPES
  } art_e;

  // Predicts the cut path of each loaded image and holds the row results still owed.
  class cut_path_checker;
    logic [PIX_W-1:0] image_mem [STORE_DEPTH];
    logic [COL_W-1:0] row_cut [MAX_HEIGHT];
    int unsigned      fill_pos;
    int               width_raw;
    int               height_raw;
    result_t          pending_cuts [$];
    int               errors;

    function new();
      fill_pos   = 0;
      width_raw  = MAX_WIDTH;
      height_raw = MAX_HEIGHT;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) begin
        width_raw = value;
      end else begin
        height_raw = value;
      end
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum.
    function int eff_dim(int raw, int maxv);
      if (raw == 0) return 1;
      if (raw > maxv) return maxv;
      return raw;
    endfunction

    // Outside the image everything reads as white.
    function int pel(int r, int c, int w, int h);
      if (r < 0 || c < 0 || r >= h || c >= w) return PIX_WHITE;
      return image_mem[r * MAX_WIDTH + c];
    endfunction

    // Longest white run from the top within [w/3, 3w/4); first one wins a tie.
    function int start_column(int w, int h);
      int best_run, pick, run, i, j;
      best_run = 0;
      pick     = w / 2;
      for (i = w / 3; i < (w * 3) / 4; i++) begin
        run = 0;
        for (j = 0; j < h && pel(j, i, w, h) == PIX_WHITE; j++) run++;
        if (run > best_run) begin
          best_run = run;
          pick     = i;
        end
      end
      return pick;
    endfunction

    function void trace_image(int w, int h);
      int col, row, lo, hi, k;
      int nl, nr, nd, ndl, ndr;
      bit side_step, all_black, all_white;
      result_t res;
      foreach (row_cut[k]) row_cut[k] = '0;
      col       = start_column(w, h);
      row       = 0;
      side_step = 1'b0;
      lo        = col;
      hi        = col;
      row_cut[0] = COL_W'(col);
      while (col > 0 && col < w - 1 && row < h - 1) begin
        nl  = pel(row, col - 1, w, h);
        nr  = pel(row, col + 1, w, h);
        nd  = pel(row + 1, col, w, h);
        ndl = pel(row + 1, col - 1, w, h);
        ndr = pel(row + 1, col + 1, w, h);
        all_black = nl == PIX_BLACK && nr == PIX_BLACK && nd == PIX_BLACK &&
                    ndl == PIX_BLACK && ndr == PIX_BLACK;
        all_white = nl == PIX_WHITE && nr == PIX_WHITE && nd == PIX_WHITE &&
                    ndl == PIX_WHITE && ndr == PIX_WHITE;
        if (all_black || all_white || (ndl == PIX_BLACK && nd == PIX_WHITE)) begin
          row++;
          side_step = 1'b0;
        end else if (nl == PIX_BLACK && nr == PIX_BLACK && nd == PIX_BLACK &&
                     ndl == PIX_WHITE && ndr == PIX_BLACK) begin
          row++;
          col--;
          side_step = 1'b0;
        end else if (nd == PIX_BLACK && ndl == PIX_BLACK && ndr == PIX_WHITE) begin
          row++;
          col++;
          side_step = 1'b0;
        end else if (nr == PIX_WHITE && nd == PIX_BLACK && ndl == PIX_BLACK &&
                     ndr == PIX_BLACK) begin
          if (!side_step) begin
            col++;
            side_step = 1'b1;
          end else begin
            row++;
            side_step = 1'b0;
          end
        end else if (nl == PIX_WHITE && nd == PIX_BLACK && ndl == PIX_BLACK &&
                     ndr == PIX_BLACK) begin
          if (!side_step) begin
            col--;
            side_step = 1'b1;
          end else begin
            row++;
            side_step = 1'b0;
          end
        end else begin
          row++;
        end
        if (col < lo) lo = col;
        if (col > hi) hi = col;
        row_cut[row % MAX_HEIGHT] = COL_W'(col);
      end
      for (k = 0; k < h && k < MAX_HEIGHT; k++) begin
        res.row_index    = ROW_W'(k);
        res.cut_column   = row_cut[k];
        res.split_status = (lo <= 0 || hi <= 0);
        res.min_column   = COL_W'(lo);
        res.max_column   = COL_W'(hi);
        res.last_result  = (k == h - 1 || k == MAX_HEIGHT - 1);
        pending_cuts.push_back(res);
      end
    endfunction

    // Store the pixel at its raster place; the final pixel triggers the trace.
    function void note_pixel(pixel_in_t item);
      int w, h;
      int unsigned r, c;
      w = eff_dim(width_raw, MAX_WIDTH);
      h = eff_dim(height_raw, MAX_HEIGHT);
      r = fill_pos / w;
      c = fill_pos % w;
      if (r < h) image_mem[r * MAX_WIDTH + c] = item.pixel;
      if (fill_pos < STORE_DEPTH) fill_pos++;
      if (item.last_pixel) begin
        fill_pos = 0;
        trace_image(w, h);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_cuts.size() == 0) begin
        errors++;
        $display("%0t: row result with none expected, expected nothing, actual %p",
                 $time, got);
        return;
      end
      want = pending_cuts.pop_front();
      compare_field("row_index", want.row_index, got.row_index);
      compare_field("cut_column", want.cut_column, got.cut_column);
      compare_field("split_status", want.split_status, got.split_status);
      compare_field("min_column", want.min_column, got.min_column);
      compare_field("max_column", want.max_column, got.max_column);
      compare_field("last_result", want.last_result, got.last_result);
    endfunction

    function bit drained();
      return pending_cuts.size() == 0;
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DIM_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  pixel_in_t            in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  result_t              out_data_o;

  cut_path_checker cut_paths = new();

  // Shared knobs between the sender, the receiver and the main sequence.
  bit idling_on    = 1'b1;
  bit hold_request = 1'b0;
  int cycle_count  = 0;

  drop_fall_split_trace u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one pixel transaction, optionally after a random gap, and hold it until taken.
  // Valid stays high on return so back-to-back pixels never drop it within a step.
  task automatic send_pixel(logic [PIX_W-1:0] value, bit last);
    pixel_in_t item;
    item.pixel      = value;
    item.last_pixel = last;
    if (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    cut_paths.note_pixel(item);
  endtask

  // Build a w x h picture, then stream it; extra pixels past the image get dropped by
  // the block and the final one carries last_pixel.
  task automatic send_image(int w, int h, int extra, art_e art);
    logic [PIX_W-1:0] canvas [STORE_DEPTH];
    int i, b, x0, x1, y0, y1, x, y, total, roll;
    total = w * h + extra;
    for (i = 0; i < w * h; i++) begin
      roll = $urandom_range(99);
      case (art)
        ART_NOISE: begin
          canvas[i] = roll < 42 ? PIX_WHITE : roll < 84 ? PIX_BLACK : $urandom_range(0, 255);
        end
        ART_WHITE: canvas[i] = PIX_WHITE;
        ART_BLACK: canvas[i] = PIX_BLACK;
        ART_STRIPES: canvas[i] = ((i % w) % 2 == 0) ? PIX_BLACK : PIX_WHITE;
        default: canvas[i] = PIX_WHITE;
      endcase
    end
    // Glyphs: drop a few black blocks on white, then sprinkle some grey noise.
    if (art == ART_GLYPHS) begin
      for (b = $urandom_range(1, 3); b > 0; b--) begin
        x0 = $urandom_range(0, w - 1);
        x1 = x0 + $urandom_range(0, (w + 1) / 2);
        y0 = $urandom_range(0, h - 1);
        y1 = y0 + $urandom_range(0, h - 1);
        for (y = y0; y <= y1 && y < h; y++)
          for (x = x0; x <= x1 && x < w; x++) canvas[y * w + x] = PIX_BLACK;
      end
      for (i = 0; i < w * h; i++)
        if ($urandom_range(99) < 6) canvas[i] = $urandom_range(0, 255);
    end
    for (i = 0; i < total; i++)
      send_pixel(i < w * h ? canvas[i] : PIX_W'($urandom_range(0, 255)), i == total - 1);
  endtask

  // Wait for every owed result, then give the block time to go quiet.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (!cut_paths.drained()) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both size registers while the block is idle.
  task automatic write_dims(logic [DIM_W-1:0] w_raw, logic [DIM_W-1:0] h_raw);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_data_i  <= w_raw;
    @(posedge clk_i);
    cut_paths.write_reg(REG_IMAGE_WIDTH, w_raw);
    cfg_index_i <= REG_IMAGE_HEIGHT;
    cfg_data_i  <= h_raw;
    @(posedge clk_i);
    cut_paths.write_reg(REG_IMAGE_HEIGHT, h_raw);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver: random stalls, a calm stretch when idling is off, and one long hold-off
  // that backs the block up until it stalls its pixel input.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idling_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Check every accepted result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) cut_paths.check_result(out_data_o);
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int pixels_sent, phase, n_img, w_raw, h_raw, w, h, extra, roll, i;
    art_e art;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes: one full 64 x 64 image plus surplus pixels, so the load position
    // saturates at the store depth.
    send_image(MAX_WIDTH, MAX_HEIGHT, 3, ART_GLYPHS);

    // Directed: single pixel, solid black, stripes, surplus pixels on a tiny image.
    write_dims(1, 1);
    send_image(1, 1, 0, ART_WHITE);
    write_dims(3, 3);
    send_image(3, 3, 0, ART_BLACK);
    write_dims(3, 2);
    send_image(3, 2, 0, ART_STRIPES);
    write_dims(2, 2);
    send_image(2, 2, 3, ART_NOISE);

    // Out-of-range register values: zero acts as one, too large acts as the maximum.
    write_dims(0, 127);
    send_image(1, MAX_HEIGHT, 0, ART_NOISE);
    write_dims(100, 0);
    send_image(MAX_WIDTH, 1, 0, ART_GLYPHS);
    write_dims(64, 2);
    send_image(MAX_WIDTH, 2, 0, ART_NOISE);

    // Random phases: mostly glyph-like images, some pure noise.
    pixels_sent = 0;
    phase       = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      roll = $urandom_range(99);
      if (roll < 5) w_raw = 0;
      else if (roll < 10) w_raw = $urandom_range(65, 127);
      else if (roll < 25) w_raw = $urandom_range(1, 2);
      else if (roll < 85) w_raw = $urandom_range(3, 10);
      else w_raw = $urandom_range(11, 24);
      if (w_raw > 24) h_raw = $urandom_range(1, 3);
      else if ($urandom_range(99) < 5) h_raw = 0;
      else h_raw = $urandom_range(1, 10);
      // The hold-off phase needs several multi-pixel images queued behind the first.
      if (phase == 4) begin
        w_raw = 6;
        h_raw = 5;
      end
      write_dims(w_raw, h_raw);
      w = cut_paths.eff_dim(w_raw, MAX_WIDTH);
      h = cut_paths.eff_dim(h_raw, MAX_HEIGHT);
      idling_on = (phase != 2);
      if (phase == 4) hold_request = 1'b1;
      n_img = (phase == 2 || phase == 4) ? 5 : $urandom_range(1, 3);
      for (i = 0; i < n_img; i++) begin
        art   = ($urandom_range(99) < 75) ? ART_GLYPHS : ART_NOISE;
        extra = ($urandom_range(99) < 10) ? $urandom_range(1, 5) : 0;
        send_image(w, h, extra, art);
        pixels_sent += w * h + extra;
      end
      phase++;
    end
    idling_on = 1'b1;

    wait_drained();
    if (cut_paths.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
